[rtl/cpsa_pkg.sv]
// Shared types and constants for the color palette slot allocator.
package cpsa_pkg;

    localparam int PALETTE_SLOTS_DEFAULT = 256;
    localparam int INDEX_W               = 8;
    localparam int FIND_GROUP            = 16;

    localparam logic [31:0] RGBA_BLACK = 32'h0000_00FF;
    localparam logic [31:0] RGBA_WHITE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [INDEX_W-1:0] color_index;
    } cpsa_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] result_index;
        logic [1:0]         status;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_alpha;
    } cpsa_rsp_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] slot;
    } cpsa_find_t;

endpackage

[rtl/cpsa_stream_if.sv]
// Valid/ready stream interface carrying one payload per transaction.
interface cpsa_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/cpsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cpsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/cpsa_find.sv]
// Two-level first-free slot finder: registered per-group encoders, then group select.
module cpsa_find #(
    parameter int SLOTS = cpsa_pkg::PALETTE_SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic [SLOTS-1:0]      free_vec,
    output cpsa_pkg::cpsa_find_t  result
);
    import cpsa_pkg::*;

    localparam int NG   = (SLOTS + FIND_GROUP - 1) / FIND_GROUP;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int LW   = $clog2(FIND_GROUP);
    localparam int PADW = NG * FIND_GROUP;

    logic [PADW-1:0] pad_vec;
    logic [NG-1:0]   grp_any_next;
    logic [LW-1:0]   grp_low_next [NG];
    logic [NG-1:0]   grp_any_reg;
    logic [LW-1:0]   grp_low_reg  [NG];
    logic [GW-1:0]   sel;

    assign pad_vec = PADW'(free_vec);

    // Lowest free bit inside each group.
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = |pad_vec[g*FIND_GROUP +: FIND_GROUP];
            grp_low_next[g] = '0;
            for (int b = FIND_GROUP - 1; b >= 0; b--)
            begin
                if (pad_vec[g*FIND_GROUP + b])
                begin
                    grp_low_next[g] = LW'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_any_reg <= grp_any_next;
        for (int g = 0; g < NG; g++)
        begin
            grp_low_reg[g] <= grp_low_next[g];
        end
    end

    // Lowest group that holds a free slot.
    always_comb
    begin
        sel = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                sel = GW'(g);
            end
        end
        result.found = |grp_any_reg;
        result.slot  = INDEX_W'({sel, grp_low_reg[sel]});
    end
endmodule

[rtl/color_palette_slot_allocator.sv]
// Top level of the color palette slot allocator.
//
//   port  | modport | payload     | role
//   ------+---------+-------------+---------------------------------------
//   req   | sink    | cpsa_req_t  | allocate / free / read commands
//   rsp   | source  | cpsa_rsp_t  | one response per command
//
// On accept the command is captured and the entry RAM read is issued, while
// the per-group free-slot encoders are registered; in S_EXEC the block selects
// the slot, writes the RAM and loads the response register.
// A new command is taken while a response still waits in the output register;
// a command in S_EXEC holds until that register is free.
// Reset restores black and white in entries 0 and 1 and a use count of two.
module color_palette_slot_allocator #(
    parameter int PALETTE_SLOTS = cpsa_pkg::PALETTE_SLOTS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    cpsa_stream_if.sink   req,
    cpsa_stream_if.source rsp
);
    import cpsa_pkg::*;

    localparam int CAP = (PALETTE_SLOTS < 256) ? PALETTE_SLOTS : 256;
    localparam int IW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    cpsa_req_t        req_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CAP-1:0]   free_reg, free_next;
    cpsa_rsp_t        rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             accept;
    logic             exec_go;
    logic [2**IW-1:0] free_pad;
    logic [IW-1:0]    idx_lo;
    logic             live;
    logic             can_append;
    logic [IW-1:0]    slot;
    logic             ram_we;
    logic [IW-1:0]    ram_raddr;
    logic [31:0]      ram_rdata;
    logic [31:0]      entry;
    cpsa_find_t       find;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    cpsa_find #(
        .SLOTS (CAP)
    ) u_find (
        .clk      (clk),
        .free_vec (free_reg),
        .result   (find)
    );

    // Keep reading the held index while a command waits on the response register.
    assign ram_raddr = (state_reg == S_IDLE) ? req.data.color_index[IW-1:0] : idx_lo;

    cpsa_ram #(
        .WIDTH (32),
        .DEPTH (CAP)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata ({req_reg.red, req_reg.green, req_reg.blue, req_reg.alpha}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign free_pad   = (2**IW)'(free_reg);
    assign idx_lo     = req_reg.color_index[IW-1:0];
    assign live       = (9'(req_reg.color_index) < 9'(count_reg)) && !free_pad[idx_lo];
    assign can_append = (9'(count_reg) < 9'(CAP));
    assign slot       = find.found ? IW'(find.slot) : IW'(count_reg);
    assign ram_we     = exec_go && (req_reg.mode == MODE_ALLOC)
                        && (find.found || can_append);

    // Built-in entries are never written, so serve them from constants.
    always_comb
    begin
        if (req_reg.color_index == INDEX_W'(0))
        begin
            entry = RGBA_BLACK;
        end
        else if (req_reg.color_index == INDEX_W'(1))
        begin
            entry = RGBA_WHITE;
        end
        else
        begin
            entry = ram_rdata;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    rsp_next.status = STAT_INVALID;
                    unique case (req_reg.mode)
                        MODE_ALLOC:
                        begin
                            if (find.found)
                            begin
                                free_next[slot]       = 1'b0;
                                rsp_next.result_index = INDEX_W'(slot);
                                rsp_next.status       = STAT_OK;
                            end
                            else if (can_append)
                            begin
                                count_next            = count_reg + CW'(1);
                                rsp_next.result_index = INDEX_W'(slot);
                                rsp_next.status       = STAT_OK;
                            end
                            else
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                        end
                        MODE_FREE:
                        begin
                            if (req_reg.color_index == INDEX_W'(0))
                            begin
                                rsp_next.status = STAT_OK;
                            end
                            else if (req_reg.color_index != INDEX_W'(1) && live)
                            begin
                                free_next[idx_lo]     = 1'b1;
                                rsp_next.result_index = req_reg.color_index;
                                rsp_next.status       = STAT_OK;
                            end
                        end
                        MODE_READ:
                        begin
                            if (live)
                            begin
                                rsp_next.result_index = req_reg.color_index;
                                rsp_next.status       = STAT_OK;
                                rsp_next.out_red      = entry[31:24];
                                rsp_next.out_green    = entry[23:16];
                                rsp_next.out_blue     = entry[15:8];
                                rsp_next.out_alpha    = entry[7:0];
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STAT_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(2);
            free_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: capture the command, hold the response.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req.data;
        end
        rsp_reg <= rsp_next;
    end
endmodule

[verif/color_palette_slot_allocator_tb.sv]
// Self-checking testbench for the palette slot allocator: directed and random command streams.
module color_palette_slot_allocator_tb;

    import cpsa_pkg::*;

    localparam int          SLOTS        = PALETTE_SLOTS_DEFAULT;
    localparam int          CAPACITY     = (SLOTS < 256) ? SLOTS : 256;
    localparam int          RANDOM_ITEMS = 1900;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          PRINT_CAP    = 40;
    localparam logic [1:0]  MODE_UNDEF   = 2'd3;

    typedef struct {
        cpsa_req_t cmd;
        cpsa_rsp_t want;
    } palette_op_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cpsa_stream_if #(.T(cpsa_req_t)) req_if ();
    cpsa_stream_if #(.T(cpsa_rsp_t)) rsp_if ();

    color_palette_slot_allocator #(.PALETTE_SLOTS(SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // Shadow palette state
    logic [31:0] pal_rgba [0:SLOTS-1];
    bit          pal_used [0:SLOTS-1];
    int          pal_high;

    palette_op_t cmd_queue [$];
    cpsa_rsp_t   awaited_rsp [$];

    int  total_cmds;
    int  sent_count;
    int  idle_cycles;
    int  mismatch_count;
    int  rsp_checked;
    int  n_alloc, n_free, n_read, n_undef, n_full;
    bit  req_fired;
    bit  hold_request;
    bit  hold_started;
    int  hold_left;
    int  hold_at;
    cpsa_rsp_t got_rsp;
    cpsa_rsp_t want_rsp;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void palette_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            pal_rgba[i] = '0;
            pal_used[i] = 1'b0;
        end
        pal_rgba[0] = RGBA_BLACK;
        pal_rgba[1] = RGBA_WHITE;
        pal_used[0] = 1'b1;
        pal_used[1] = 1'b1;
        pal_high    = 2;
    endfunction

    // Advance the shadow palette by one command and return its response.
    function automatic cpsa_rsp_t palette_apply(cpsa_req_t c);
        cpsa_rsp_t r;
        int        slot;
        bit        found;
        bit        live;
        r        = '0;
        r.status = STAT_INVALID;
        slot     = 0;
        found    = 1'b0;
        live     = (int'(c.color_index) < pal_high) && pal_used[c.color_index];
        case (c.mode)
            MODE_ALLOC:
            begin
                for (int i = 0; i < pal_high && !found; i++)
                begin
                    if (!pal_used[i])
                    begin
                        slot  = i;
                        found = 1'b1;
                    end
                end
                if (!found && pal_high >= CAPACITY)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    if (!found)
                    begin
                        slot     = pal_high;
                        pal_high = pal_high + 1;
                    end
                    pal_rgba[slot] = {c.red, c.green, c.blue, c.alpha};
                    pal_used[slot] = 1'b1;
                    r.result_index = 8'(slot);
                    r.status       = STAT_OK;
                end
            end
            MODE_FREE:
            begin
                if (c.color_index == 8'd0)
                begin
                    r.status = STAT_OK;
                end
                else if (c.color_index != 8'd1 && live)
                begin
                    pal_used[c.color_index] = 1'b0;
                    r.result_index          = c.color_index;
                    r.status                = STAT_OK;
                end
            end
            MODE_READ:
            begin
                if (live)
                begin
                    r.result_index = c.color_index;
                    r.status       = STAT_OK;
                    {r.out_red, r.out_green, r.out_blue, r.out_alpha} = pal_rgba[c.color_index];
                end
            end
            default:
            begin
                r.status = STAT_INVALID;
            end
        endcase
        return r;
    endfunction

    function automatic void queue_cmd(logic [1:0] mode, logic [31:0] rgba, logic [7:0] idx);
        palette_op_t op;
        op.cmd.mode        = mode;
        op.cmd.red         = rgba[31:24];
        op.cmd.green       = rgba[23:16];
        op.cmd.blue        = rgba[15:8];
        op.cmd.alpha       = rgba[7:0];
        op.cmd.color_index = idx;
        op.want            = palette_apply(op.cmd);
        cmd_queue.push_back(op);
    endfunction

    // Lean toward the channel extremes now and then.
    function automatic logic [7:0] chan_val();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return 8'h00;
        else if (roll == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] random_rgba();
        return {chan_val(), chan_val(), chan_val(), chan_val()};
    endfunction

    function automatic logic [7:0] pick_live_slot();
        logic [7:0] live_slots [$];
        for (int i = 0; i < pal_high; i++)
        begin
            if (pal_used[i])
                live_slots.push_back(8'(i));
        end
        return live_slots[$urandom_range(0, live_slots.size() - 1)];
    endfunction

    function automatic void build_stimulus();
        int kind;
        int len;
        // Directed: built-in entries, unused entries, reuse and top-slot free
        queue_cmd(MODE_READ,  32'h0, 8'd0);
        queue_cmd(MODE_READ,  32'h0, 8'd1);
        queue_cmd(MODE_READ,  32'h0, 8'd2);
        queue_cmd(MODE_FREE,  32'h0, 8'd0);
        queue_cmd(MODE_FREE,  32'h0, 8'd1);
        queue_cmd(MODE_FREE,  32'h0, 8'd255);
        queue_cmd(MODE_UNDEF, 32'hFFFF_FFFF, 8'd255);
        queue_cmd(MODE_UNDEF, 32'h0, 8'd0);
        queue_cmd(MODE_ALLOC, 32'h0000_0000, 8'd0);
        queue_cmd(MODE_ALLOC, 32'hFFFF_FFFF, 8'd255);
        queue_cmd(MODE_ALLOC, 32'hA55A_0FF0, 8'd17);
        queue_cmd(MODE_READ,  32'h0, 8'd2);
        queue_cmd(MODE_READ,  32'h0, 8'd3);
        queue_cmd(MODE_READ,  32'h0, 8'd4);
        queue_cmd(MODE_FREE,  32'h0, 8'd3);
        queue_cmd(MODE_READ,  32'h0, 8'd3);
        queue_cmd(MODE_ALLOC, 32'h1234_5678, 8'd0);
        queue_cmd(MODE_READ,  32'h0, 8'd3);
        queue_cmd(MODE_FREE,  32'h0, 8'd4);
        queue_cmd(MODE_FREE,  32'h0, 8'd4);
        queue_cmd(MODE_ALLOC, 32'h8001_7FFE, 8'd0);
        queue_cmd(MODE_READ,  32'h0, 8'd4);
        queue_cmd(MODE_READ,  32'h0, 8'd255);
        queue_cmd(MODE_FREE,  32'h0, 8'd5);

        // Random bursts of well-formed traffic plus some noise
        while (cmd_queue.size() < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                len = $urandom_range(1, 24);
                repeat (len) queue_cmd(MODE_ALLOC, random_rgba(), 8'($urandom));
            end
            else if (kind < 42)
            begin
                len = $urandom_range(20, 60);
                repeat (len) queue_cmd(MODE_FREE, random_rgba(), pick_live_slot());
            end
            else if (kind < 60)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    if ($urandom_range(0, 9) != 0)
                        queue_cmd(MODE_FREE, random_rgba(), pick_live_slot());
                    else
                        queue_cmd(MODE_FREE, random_rgba(), 8'($urandom));
                end
            end
            else if (kind < 85)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    if ($urandom_range(0, 6) != 0)
                        queue_cmd(MODE_READ, random_rgba(), pick_live_slot());
                    else
                        queue_cmd(MODE_READ, random_rgba(), 8'($urandom));
                end
            end
            else
            begin
                len = $urandom_range(1, 6);
                repeat (len) queue_cmd(2'($urandom), 32'($urandom), 8'($urandom));
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("response %0d %s got %h want %h",
                                      rsp_checked, name, got, want));
    endtask

    function automatic int idle_phase();
        if (sent_count * 3 < total_cmds)
            return 0;
        else if (sent_count * 3 < total_cmds * 2)
            return 1;
        return 2;
    endfunction

    // Command driver: hold an offer until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else if (req_if.valid && !req_fired)
        begin
            req_if.valid <= 1'b1;
        end
        else if (cmd_queue.size() != 0 &&
                 (idle_phase() != 0 || $urandom_range(0, 99) >= 32) &&
                 (idle_phase() != 1 || $urandom_range(0, 99) >= 68))
        begin
            req_if.valid <= 1'b1;
            req_if.data  <= cmd_queue[0].cmd;
        end
        else
        begin
            req_if.valid <= 1'b0;
        end
        if (rst_n && sent_count >= hold_at)
            hold_request = 1'b1;
    end

    // Response sink
    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
            rsp_if.ready <= 1'b0;
        else if (idle_phase() == 0)
            rsp_if.ready <= ($urandom_range(0, 99) >= 68);
        else if (idle_phase() == 1)
            rsp_if.ready <= ($urandom_range(0, 99) >= 32);
        else
            rsp_if.ready <= 1'b1;
    end

    // Long back-pressure stretch so the block fills and stalls its input
    always @(posedge clk)
    begin
        if (hold_request && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
        end
    end

    // Monitor: record accepted commands, check responses in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_fired = req_if.valid && req_if.ready;
            if (req_fired)
            begin
                case (cmd_queue[0].cmd.mode)
                    MODE_ALLOC: n_alloc++;
                    MODE_FREE:  n_free++;
                    MODE_READ:  n_read++;
                    default:    n_undef++;
                endcase
                awaited_rsp.push_back(cmd_queue[0].want);
                void'(cmd_queue.pop_front());
                sent_count++;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                got_rsp = rsp_if.data;
                if (awaited_rsp.size() == 0)
                begin
                    report_mismatch($sformatf("response with none outstanding: %h", got_rsp));
                end
                else
                begin
                    want_rsp = awaited_rsp.pop_front();
                    if (want_rsp.status == STAT_FULL)
                        n_full++;
                    check_field("result_index", got_rsp.result_index, want_rsp.result_index);
                    check_field("status", 8'(got_rsp.status), 8'(want_rsp.status));
                    check_field("out_red", got_rsp.out_red, want_rsp.out_red);
                    check_field("out_green", got_rsp.out_green, want_rsp.out_green);
                    check_field("out_blue", got_rsp.out_blue, want_rsp.out_blue);
                    check_field("out_alpha", got_rsp.out_alpha, want_rsp.out_alpha);
                    rsp_checked++;
                end
            end
            if (req_fired || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
    end

    // Watchdog: give up when nothing moves for too long
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        rsp_if.ready   = 1'b0;
        sent_count     = 0;
        idle_cycles    = 0;
        mismatch_count = 0;
        rsp_checked    = 0;
        n_alloc        = 0;
        n_free         = 0;
        n_read         = 0;
        n_undef        = 0;
        n_full         = 0;
        req_fired      = 1'b0;
        hold_request   = 1'b0;
        hold_started   = 1'b0;
        hold_left      = 0;

        palette_reset();
        build_stimulus();
        total_cmds = cmd_queue.size();
        hold_at    = total_cmds / 2;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (awaited_rsp.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", awaited_rsp.size()));

        $display("Ran %0d commands: %0d allocate (%0d hit a full table), %0d free, %0d read, %0d bad mode",
                 sent_count, n_alloc, n_full, n_free, n_read, n_undef);
        $display("Checked %0d responses across three idle patterns and one long stall, %0d mismatches",
                 rsp_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
